FILE: src/crc_checked_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// CRC-checked frame receiver assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define CRC_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Plain assertion on the rising clock edge, disabled while reset is low.
`define CCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Assertion that only applies while a result is presented.
`define CCFR_ASSERT_OUT(lbl, prop, msg) \
  `CCFR_ASSERT(lbl, out_valid_o |-> (prop), msg)

`endif

FILE: src/ccfr_pkg.sv
// ----------------------------------------------------------------------------
// CRC-checked frame receiver package
// Payload types, codes, frame constants and the CRC-16/ARC byte update.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  localparam int unsigned FRAME_BUFFER_BYTES = 1024;
  localparam int unsigned LEN_BOUND = FRAME_BUFFER_BYTES - 6;
  localparam int unsigned LEN_SAT   = (LEN_BOUND > 1023) ? 1023 : LEN_BOUND;
  localparam int unsigned FLEN_W    = $clog2(LEN_BOUND + 1);
  localparam int unsigned PAY_LEN_W = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [7:0]  START_BYTE = 8'hEE;
  localparam logic [7:0]  SYNC_A     = 8'h20;
  localparam logic [7:0]  SYNC_B     = 8'h21;
  localparam logic [15:0] CRC_POLY_R = 16'hA001;  // 0x8005 bit-reversed

  // Request types and their reply types
  localparam logic [7:0] TYPE_ERASE    = 8'h02;
  localparam logic [7:0] TYPE_REQ_04   = 8'h04;
  localparam logic [7:0] TYPE_REQ_06   = 8'h06;
  localparam logic [7:0] TYPE_LOGIN    = 8'h12;
  localparam logic [7:0] TYPE_REQ_16   = 8'h16;
  localparam logic [7:0] TYPE_REQ_19   = 8'h19;
  localparam logic [7:0] TYPE_TEST     = 8'h21;
  localparam logic [7:0] TYPE_END_TEST = 8'h23;

  localparam logic [7:0] RTYPE_ERASE    = 8'h03;
  localparam logic [7:0] RTYPE_REQ_04   = 8'h05;
  localparam logic [7:0] RTYPE_REQ_06   = 8'h07;
  localparam logic [7:0] RTYPE_LOGIN    = 8'h13;
  localparam logic [7:0] RTYPE_REQ_16   = 8'h17;
  localparam logic [7:0] RTYPE_REQ_19   = 8'h20;
  localparam logic [7:0] RTYPE_TEST     = 8'h22;
  localparam logic [7:0] RTYPE_END_TEST = 8'h24;

  localparam logic [7:0] FIXED_ACK_CODE = 8'h06;

  // Register reset values
  localparam logic [7:0] ERASE_CODE_RST    = 8'd2;
  localparam logic [7:0] LOGIN_CODE_RST    = 8'd1;
  localparam logic [7:0] TEST_CODE_RST     = 8'd6;
  localparam logic [7:0] END_TEST_CODE_RST = 8'd6;
  localparam logic [7:0] IDLE_LIMIT_RST    = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERASE_CODE,
    CFG_LOGIN_CODE,
    CFG_TEST_CODE,
    CFG_END_TEST_CODE,
    CFG_IDLE_LIMIT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_SYNC,
    ST_BAD_CRC,
    ST_BAD_LEN
  } frame_status_e;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SYNC,
    PH_BODY,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           frame_status;
    logic [7:0]           message_type;
    logic [PAY_LEN_W-1:0] payload_length;
    logic                 has_reply;
    logic [7:0]           reply_type;
    logic [7:0]           reply_sync;
    logic [7:0]           reply_code;
    logic [15:0]          reply_crc;
    logic [15:0]          computed_crc;
    logic [15:0]          received_crc;
  } out_item_t;

  typedef struct packed {
    logic [7:0] erase_code;
    logic [7:0] login_code;
    logic [7:0] test_code;
    logic [7:0] end_test_code;
  } reply_codes_t;

  typedef struct packed {
    logic        has_reply;
    logic [7:0]  reply_type;
    logic [7:0]  reply_code;
    logic [15:0] reply_crc;
  } reply_t;

  // One byte of reflected CRC-16/ARC, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_R) : (c >> 1);
    end
    return c;
  endfunction

  // Clamp a length field to the reportable range
  function automatic logic [PAY_LEN_W-1:0] sat_length(input logic [15:0] len);
    if (len > 16'(LEN_SAT)) begin
      return PAY_LEN_W'(LEN_SAT);
    end
    return len[PAY_LEN_W-1:0];
  endfunction

endpackage

FILE: src/ccfr_reply_gen.sv
// ----------------------------------------------------------------------------
// CRC-checked frame receiver reply generator
// Maps a request type to the reply type, status code and reply CRC.
// ----------------------------------------------------------------------------
module ccfr_reply_gen (
  input  logic [7:0]            msg_type_i,
  input  ccfr_pkg::reply_codes_t codes_i,
  output ccfr_pkg::reply_t      reply_o
);

  logic       known;
  logic [7:0] rtype;
  logic [7:0] rcode;

  always_comb begin
    known = 1'b1;
    rtype = 8'h00;
    rcode = 8'h00;
    case (msg_type_i)
      ccfr_pkg::TYPE_ERASE: begin
        rtype = ccfr_pkg::RTYPE_ERASE;
        rcode = codes_i.erase_code;
      end
      ccfr_pkg::TYPE_REQ_04: begin
        rtype = ccfr_pkg::RTYPE_REQ_04;
      end
      ccfr_pkg::TYPE_REQ_06: begin
        rtype = ccfr_pkg::RTYPE_REQ_06;
      end
      ccfr_pkg::TYPE_LOGIN: begin
        rtype = ccfr_pkg::RTYPE_LOGIN;
        rcode = codes_i.login_code;
      end
      ccfr_pkg::TYPE_REQ_16: begin
        rtype = ccfr_pkg::RTYPE_REQ_16;
        rcode = ccfr_pkg::FIXED_ACK_CODE;
      end
      ccfr_pkg::TYPE_REQ_19: begin
        rtype = ccfr_pkg::RTYPE_REQ_19;
        rcode = ccfr_pkg::FIXED_ACK_CODE;
      end
      ccfr_pkg::TYPE_TEST: begin
        rtype = ccfr_pkg::RTYPE_TEST;
        rcode = codes_i.test_code;
      end
      ccfr_pkg::TYPE_END_TEST: begin
        rtype = ccfr_pkg::RTYPE_END_TEST;
        rcode = codes_i.end_test_code;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    reply_o = '0;
    if (known) begin
      reply_o.has_reply  = 1'b1;
      reply_o.reply_type = rtype;
      reply_o.reply_code = rcode;
      reply_o.reply_crc  = ccfr_pkg::crc_byte(ccfr_pkg::crc_byte(16'h0000, rtype), rcode);
    end
  end

endmodule

FILE: src/crc_checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// CRC-checked frame receiver
// Frame parser with running CRC-16/ARC check and reply descriptor output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one item per
//   transfer: a received byte (op = 0) or an idle timer tick (op = 1).
//   Output channel (out_valid_o / out_ready_i / out_data_o) carries one
//   result per finished or rejected frame: status, type, length, reply
//   descriptor and both CRCs. Bytes that do not close a frame and ticks give
//   no result.
//   Throughput: one item per cycle unless held off by an output stall. The CRC
//   update is an unrolled 8-bit step, so the parser state advances on every transfer.
//   Latency: a result shows on out_valid_o the cycle after the transfer of
//   the byte that closes the frame.
//   Stall: the output register holds a result until it is taken; while it is
//   full and out_ready_i is low, in_ready_o drops and input is held off.
//   Reset: asynchronous, active low. The parser returns to the start-byte
//   hunt, all frame state clears and the registers take their defaults.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i;
//   write only while no frame is in progress.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ccfr_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ccfr_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ccfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ccfr_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  // Configuration registers
  ccfr_pkg::reply_codes_t codes_q;
  logic [7:0]             idle_limit_q;

  // Parser state
  ccfr_pkg::phase_e              phase_q, phase_d;
  logic [ccfr_pkg::FLEN_W-1:0]   byte_cnt_q, byte_cnt_d;
  logic [ccfr_pkg::FLEN_W-1:0]   frame_len_q, frame_len_d;
  logic [7:0]                    len_hi_q, len_hi_d;
  logic [7:0]                    sync_q, sync_d;
  logic [7:0]                    type_q, type_d;
  logic [15:0]                   crc_q, crc_d;
  logic [7:0]                    crc_hi_q, crc_hi_d;
  logic [7:0]                    idle_q, idle_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  ccfr_pkg::out_item_t   out_data_q, out_data_d;

  logic                  in_xfer;
  logic                  emit;
  ccfr_pkg::out_item_t   res;
  ccfr_pkg::reply_t      reply;

  logic [15:0]                 len_field;
  logic [15:0]                 rx_crc;
  logic [7:0]                  idle_inc;
  logic [ccfr_pkg::FLEN_W-1:0] cnt_inc;
  logic [7:0]                  b;

  // Accept whenever the output register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign b         = in_data_i.data_byte;
  assign len_field = {len_hi_q, b};
  assign rx_crc    = {crc_hi_q, b};
  assign idle_inc  = idle_q + 8'd1;
  assign cnt_inc   = byte_cnt_q + ccfr_pkg::FLEN_W'(1);

  ccfr_reply_gen u_reply_gen (
    .msg_type_i (type_q),
    .codes_i    (codes_q),
    .reply_o    (reply)
  );

  // Configuration writes; out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.erase_code    <= ccfr_pkg::ERASE_CODE_RST;
      codes_q.login_code    <= ccfr_pkg::LOGIN_CODE_RST;
      codes_q.test_code     <= ccfr_pkg::TEST_CODE_RST;
      codes_q.end_test_code <= ccfr_pkg::END_TEST_CODE_RST;
      idle_limit_q          <= ccfr_pkg::IDLE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ccfr_pkg::CFG_ERASE_CODE:    codes_q.erase_code    <= cfg_data_i;
        ccfr_pkg::CFG_LOGIN_CODE:    codes_q.login_code    <= cfg_data_i;
        ccfr_pkg::CFG_TEST_CODE:     codes_q.test_code     <= cfg_data_i;
        ccfr_pkg::CFG_END_TEST_CODE: codes_q.end_test_code <= cfg_data_i;
        ccfr_pkg::CFG_IDLE_LIMIT:    idle_limit_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parser state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ccfr_pkg::PH_HUNT;
      byte_cnt_q  <= '0;
      frame_len_q <= '0;
      len_hi_q    <= '0;
      sync_q      <= '0;
      type_q      <= '0;
      crc_q       <= '0;
      crc_hi_q    <= '0;
      idle_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      byte_cnt_q  <= byte_cnt_d;
      frame_len_q <= frame_len_d;
      len_hi_q    <= len_hi_d;
      sync_q      <= sync_d;
      type_q      <= type_d;
      crc_q       <= crc_d;
      crc_hi_q    <= crc_hi_d;
      idle_q      <= idle_d;
    end
  end

  // Next state and result for the item being transferred
  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = byte_cnt_q;
    frame_len_d = frame_len_q;
    len_hi_d    = len_hi_q;
    sync_d      = sync_q;
    type_d      = type_q;
    crc_d       = crc_q;
    crc_hi_d    = crc_hi_q;
    idle_d      = idle_q;
    emit        = 1'b0;
    res         = '0;

    if (in_xfer) begin
      if (in_data_i.op) begin
        // Idle tick: count, and drop any partial frame at the limit
        if (idle_inc >= idle_limit_q || idle_limit_q == 8'd0) begin
          phase_d = ccfr_pkg::PH_HUNT;
          idle_d  = 8'd0;
        end else begin
          idle_d = idle_inc;
        end
      end else begin
        idle_d = 8'd0;
        case (phase_q)
          ccfr_pkg::PH_HUNT: begin
            if (b == ccfr_pkg::START_BYTE) begin
              phase_d     = ccfr_pkg::PH_LEN_HI;
              byte_cnt_d  = '0;
              frame_len_d = '0;
              len_hi_d    = 8'h00;
              sync_d      = 8'h00;
              type_d      = 8'h00;
              crc_d       = 16'h0000;
              crc_hi_d    = 8'h00;
            end
          end
          ccfr_pkg::PH_LEN_HI: begin
            len_hi_d = b;
            phase_d  = ccfr_pkg::PH_LEN_LO;
          end
          ccfr_pkg::PH_LEN_LO: begin
            if (len_field == 16'h0000 || len_field > 16'(ccfr_pkg::LEN_BOUND)) begin
              emit               = 1'b1;
              res.frame_status   = ccfr_pkg::ST_BAD_LEN;
              res.payload_length = ccfr_pkg::sat_length(len_field);
              phase_d            = ccfr_pkg::PH_HUNT;
            end else begin
              frame_len_d = len_field[ccfr_pkg::FLEN_W-1:0];
              phase_d     = ccfr_pkg::PH_SYNC;
            end
          end
          ccfr_pkg::PH_SYNC: begin
            sync_d = b;
            if (b != ccfr_pkg::SYNC_A && b != ccfr_pkg::SYNC_B) begin
              emit               = 1'b1;
              res.frame_status   = ccfr_pkg::ST_BAD_SYNC;
              res.payload_length = ccfr_pkg::sat_length(16'(frame_len_q));
              res.reply_sync     = ccfr_pkg::SYNC_A;
              phase_d            = ccfr_pkg::PH_HUNT;
            end else begin
              phase_d = ccfr_pkg::PH_BODY;
            end
          end
          ccfr_pkg::PH_BODY: begin
            if (byte_cnt_q == '0) begin
              type_d = b;
            end
            crc_d      = ccfr_pkg::crc_byte(crc_q, b);
            byte_cnt_d = cnt_inc;
            if (cnt_inc >= frame_len_q) begin
              phase_d = ccfr_pkg::PH_CRC_HI;
            end
          end
          ccfr_pkg::PH_CRC_HI: begin
            crc_hi_d = b;
            phase_d  = ccfr_pkg::PH_CRC_LO;
          end
          ccfr_pkg::PH_CRC_LO: begin
            emit               = 1'b1;
            res.payload_length = ccfr_pkg::sat_length(16'(frame_len_q));
            res.message_type   = type_q;
            res.reply_sync     = (sync_q == ccfr_pkg::SYNC_A) ? ccfr_pkg::SYNC_B
                                                              : ccfr_pkg::SYNC_A;
            res.computed_crc   = crc_q;
            res.received_crc   = rx_crc;
            if (rx_crc == crc_q) begin
              res.frame_status = ccfr_pkg::ST_OK;
              res.has_reply    = reply.has_reply;
              res.reply_type   = reply.reply_type;
              res.reply_code   = reply.reply_code;
              res.reply_crc    = reply.reply_crc;
            end else begin
              res.frame_status = ccfr_pkg::ST_BAD_CRC;
            end
            phase_d = ccfr_pkg::PH_HUNT;
          end
          default: begin
            phase_d = ccfr_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  // Output register: load on a new result, clear once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_xfer && emit) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: src/ccfr_checker.sv
// ----------------------------------------------------------------------------
// CRC-checked frame receiver port checker
// Port-level properties of the receiver, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "crc_checked_frame_receiver_macros.svh"

module ccfr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input ccfr_pkg::in_item_t              in_data_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input ccfr_pkg::out_item_t             out_data_o,
  input logic                            cfg_we_i,
  input logic [ccfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [ccfr_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  // A stalled result must hold
  `CCFR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  // Input is held off only by a full, stalled output register
  `CCFR_ASSERT(a_ready_cause, !in_ready_o |-> out_valid_o && !out_ready_i, "input held off without output stall")

  // A rejected length carries no frame content
  `CCFR_ASSERT_OUT(a_bad_len_empty, out_data_o.frame_status != ccfr_pkg::ST_BAD_LEN || (out_data_o.message_type == 8'h00 && out_data_o.reply_sync == 8'h00 && out_data_o.computed_crc == 16'h0000 && out_data_o.received_crc == 16'h0000), "bad length result carries frame data")

  // Only a good frame may carry a reply
  `CCFR_ASSERT_OUT(a_reply_ok, !out_data_o.has_reply || (out_data_o.frame_status == ccfr_pkg::ST_OK && out_data_o.reply_type != 8'h00), "reply on a failed frame")

  // A good frame has matching CRCs
  `CCFR_ASSERT_OUT(a_ok_crc, out_data_o.frame_status != ccfr_pkg::ST_OK || out_data_o.computed_crc == out_data_o.received_crc, "ok status with CRC mismatch")

endmodule

bind crc_checked_frame_receiver ccfr_checker u_ccfr_checker (.*);

FILE: test/frame_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame result checker
// Watches the byte/tick channel, the result channel and the register port of
// the frame receiver, predicts every frame result and compares it in order.
// ----------------------------------------------------------------------------
module frame_result_checker
  import ccfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  reply_codes_t codes;
  logic [7:0]   idle_lim;

  phase_e       parse_phase;
  logic [15:0]  body_count;
  logic [15:0]  frame_len;
  logic [7:0]   sync_byte;
  logic [7:0]   type_byte;
  logic [15:0]  body_crc;
  logic [15:0]  carried_crc;
  logic [7:0]   idle_ticks;

  out_item_t    expected_frames[$];
  int           mismatches;

  assign mismatch_count_o = mismatches;

  // Bit-serial CRC-16/ARC: shift out LSB first, fold in the reflected poly
  function automatic logic [15:0] arc_crc_update(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ 16'hA001;
      end
    end
    return r;
  endfunction

  function automatic out_item_t frame_result(input frame_status_e st);
    out_item_t  r;
    logic [7:0] rt;
    logic [7:0] rc;
    r  = '0;
    rt = '0;
    rc = '0;
    r.frame_status   = st;
    r.payload_length = (frame_len > LEN_SAT) ? PAY_LEN_W'(LEN_SAT) : frame_len[PAY_LEN_W-1:0];
    if (st == ST_BAD_LEN) begin
      return r;
    end
    r.reply_sync = (sync_byte == SYNC_A) ? SYNC_B : SYNC_A;
    if (st == ST_BAD_SYNC) begin
      return r;
    end
    r.message_type = type_byte;
    r.computed_crc = body_crc;
    r.received_crc = carried_crc;
    if (st != ST_OK) begin
      return r;
    end
    r.has_reply = 1'b1;
    case (type_byte)
      TYPE_ERASE: begin
        rt = RTYPE_ERASE;
        rc = codes.erase_code;
      end
      TYPE_REQ_04: begin
        rt = RTYPE_REQ_04;
      end
      TYPE_REQ_06: begin
        rt = RTYPE_REQ_06;
      end
      TYPE_LOGIN: begin
        rt = RTYPE_LOGIN;
        rc = codes.login_code;
      end
      TYPE_REQ_16: begin
        rt = RTYPE_REQ_16;
        rc = FIXED_ACK_CODE;
      end
      TYPE_REQ_19: begin
        rt = RTYPE_REQ_19;
        rc = FIXED_ACK_CODE;
      end
      TYPE_TEST: begin
        rt = RTYPE_TEST;
        rc = codes.test_code;
      end
      TYPE_END_TEST: begin
        rt = RTYPE_END_TEST;
        rc = codes.end_test_code;
      end
      default: begin
        r.has_reply = 1'b0;
      end
    endcase
    if (r.has_reply) begin
      r.reply_type = rt;
      r.reply_code = rc;
      r.reply_crc  = arc_crc_update(arc_crc_update(16'h0000, rt), rc);
    end
    return r;
  endfunction

  task automatic advance_parser(input in_item_t it);
    if (it.op) begin
      idle_ticks = idle_ticks + 8'd1;
      if (idle_ticks >= idle_lim || idle_lim == 8'd0) begin
        parse_phase = PH_HUNT;
        idle_ticks  = '0;
      end
      return;
    end
    idle_ticks = '0;
    case (parse_phase)
      PH_HUNT: begin
        if (it.data_byte == START_BYTE) begin
          parse_phase = PH_LEN_HI;
          frame_len   = '0;
          body_count  = '0;
          sync_byte   = '0;
          type_byte   = '0;
          body_crc    = '0;
          carried_crc = '0;
        end
      end
      PH_LEN_HI: begin
        frame_len   = {it.data_byte, 8'h00};
        parse_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len[7:0] = it.data_byte;
        if (frame_len == 16'd0 || frame_len > LEN_BOUND) begin
          expected_frames.push_back(frame_result(ST_BAD_LEN));
          parse_phase = PH_HUNT;
        end else begin
          parse_phase = PH_SYNC;
        end
      end
      PH_SYNC: begin
        sync_byte = it.data_byte;
        if (it.data_byte != SYNC_A && it.data_byte != SYNC_B) begin
          expected_frames.push_back(frame_result(ST_BAD_SYNC));
          parse_phase = PH_HUNT;
        end else begin
          parse_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (body_count == 16'd0) begin
          type_byte = it.data_byte;
        end
        body_crc   = arc_crc_update(body_crc, it.data_byte);
        body_count = body_count + 16'd1;
        if (body_count >= frame_len) begin
          parse_phase = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        carried_crc = {it.data_byte, 8'h00};
        parse_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        carried_crc[7:0] = it.data_byte;
        expected_frames.push_back(frame_result((carried_crc == body_crc) ? ST_OK : ST_BAD_CRC));
        parse_phase = PH_HUNT;
      end
      default: begin
        parse_phase = PH_HUNT;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < 100) begin
      $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic compare_frame(input out_item_t got, input out_item_t want);
    if (got.frame_status !== want.frame_status)
      report_mismatch("frame_status", 16'(got.frame_status), 16'(want.frame_status));
    if (got.message_type !== want.message_type)
      report_mismatch("message_type", 16'(got.message_type), 16'(want.message_type));
    if (got.payload_length !== want.payload_length)
      report_mismatch("payload_length", 16'(got.payload_length), 16'(want.payload_length));
    if (got.has_reply !== want.has_reply)
      report_mismatch("has_reply", 16'(got.has_reply), 16'(want.has_reply));
    if (got.reply_type !== want.reply_type)
      report_mismatch("reply_type", 16'(got.reply_type), 16'(want.reply_type));
    if (got.reply_sync !== want.reply_sync)
      report_mismatch("reply_sync", 16'(got.reply_sync), 16'(want.reply_sync));
    if (got.reply_code !== want.reply_code)
      report_mismatch("reply_code", 16'(got.reply_code), 16'(want.reply_code));
    if (got.reply_crc !== want.reply_crc)
      report_mismatch("reply_crc", got.reply_crc, want.reply_crc);
    if (got.computed_crc !== want.computed_crc)
      report_mismatch("computed_crc", got.computed_crc, want.computed_crc);
    if (got.received_crc !== want.received_crc)
      report_mismatch("received_crc", got.received_crc, want.received_crc);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes       = '{erase_code: ERASE_CODE_RST, login_code: LOGIN_CODE_RST,
                      test_code: TEST_CODE_RST, end_test_code: END_TEST_CODE_RST};
      idle_lim    = IDLE_LIMIT_RST;
      parse_phase = PH_HUNT;
      body_count  = '0;
      frame_len   = '0;
      sync_byte   = '0;
      type_byte   = '0;
      body_crc    = '0;
      carried_crc = '0;
      idle_ticks  = '0;
      expected_frames.delete();
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_ERASE_CODE:    codes.erase_code    = cfg_data_i;
          CFG_LOGIN_CODE:    codes.login_code    = cfg_data_i;
          CFG_TEST_CODE:     codes.test_code     = cfg_data_i;
          CFG_END_TEST_CODE: codes.end_test_code = cfg_data_i;
          CFG_IDLE_LIMIT:    idle_lim            = cfg_data_i;
          default: ;
        endcase
      end
      // Results trail their closing byte through the output register, so match before predicting
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result with nothing expected, status", 16'(out_data_i.frame_status),
                          16'h0000);
        end else begin
          compare_frame(out_data_i, expected_frames.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_parser(in_data_i);
      end
      pending_o <= expected_frames.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Feeds bytes and idle ticks to the frame receiver: a short directed run over
// the rejection paths and good frames, then random framed traffic across several register
// settings, with random gaps and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb;
  import ccfr_pkg::*;

  localparam int         WATCHDOG_LIMIT = 5000;  // cycles with no transfer at all
  localparam int         SQUEEZE_CYCLES = 400;
  localparam int         PHASE_ITEMS    = 150;
  localparam logic [7:0] TYPE_PLAIN     = 8'h01;  // valid frame type, no reply

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int                   mismatch_count;
  int                   pending_frames;
  int                   items_sent;
  int                   stall_cycles;
  logic [7:0]           cur_idle_limit;
  bit                   burst_mode;
  bit                   squeeze_req;
  bit                   squeeze_done;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  crc_checked_frame_receiver uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  frame_result_checker u_frame_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_frames)
  );

  // Gap length shared by both sides: mostly none or short, now and then long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and hold it until the transfer; call at a rising edge
  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    gap = burst_mode ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'({op, b});
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Ticks carry a random data byte so the ignored field toggles too
  task automatic send_ticks(input int n);
    repeat (n) send_item(1'b1, 8'($urandom));
  endtask

  task automatic send_header(input logic [15:0] len);
    send_item(1'b0, START_BYTE);
    send_item(1'b0, len[15:8]);
    send_item(1'b0, len[7:0]);
  endtask

  // Send a complete frame; optionally spoil the trailing CRC and sprinkle
  // idle ticks between body bytes
  task automatic send_frame(input logic [7:0] msg_type, input int len, input logic [7:0] sync,
                            input bit corrupt, input int tick_pct);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = '0;
    send_header(16'(len));
    send_item(1'b0, sync);
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? msg_type : 8'($urandom);
      if ($urandom_range(0, 99) < tick_pct) begin
        send_ticks($urandom_range(1, 3));
      end
      crc = crc_byte(crc, b);
      send_item(1'b0, b);
    end
    if (corrupt) begin
      crc = crc ^ 16'($urandom_range(1, 65535));
    end
    send_item(1'b0, crc[15:8]);
    send_item(1'b0, crc[7:0]);
  endtask

  function automatic logic [7:0] pick_type();
    logic [7:0] known[8];
    int         r;
    known = '{TYPE_ERASE, TYPE_REQ_04, TYPE_REQ_06, TYPE_LOGIN,
              TYPE_REQ_16, TYPE_REQ_19, TYPE_TEST, TYPE_END_TEST};
    r = $urandom_range(0, 9);
    if (r < 6) return known[$urandom_range(0, 7)];
    if (r < 7) return TYPE_PLAIN;
    return 8'($urandom);
  endfunction

  // Keep most bodies tiny; a rare one runs long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 299);
    if (r == 0) return $urandom_range(100, LEN_BOUND);
    if (r < 60) return $urandom_range(7, 40);
    return $urandom_range(1, 6);
  endfunction

  task automatic write_reg(input cfg_reg_e which, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic write_registers(input logic [7:0] erase, input logic [7:0] login,
                                 input logic [7:0] test, input logic [7:0] end_test,
                                 input logic [7:0] idle);
    write_reg(CFG_ERASE_CODE, erase);
    write_reg(CFG_LOGIN_CODE, login);
    write_reg(CFG_TEST_CODE, test);
    write_reg(CFG_END_TEST_CODE, end_test);
    write_reg(CFG_IDLE_LIMIT, idle);
    cfg_we <= 1'b0;
    cur_idle_limit = idle;
  endtask

  // Drop valid, wait out every expected result, then let the output register settle
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_frames != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Force the parser back to the hunt with idle ticks, then drain, so a
  // register write never lands inside a frame
  task automatic settle();
    send_ticks((cur_idle_limit == 8'd0) ? 1 : int'(cur_idle_limit));
    drain();
  endtask

  task automatic run_phase(input int n_items);
    int         target;
    int         r;
    int         len;
    logic [7:0] s;
    target = items_sent + n_items;
    while (items_sent < target) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // Well-formed frame with random content, mostly with a good CRC
        s = ($urandom_range(0, 1) == 1) ? SYNC_B : SYNC_A;
        send_frame(pick_type(), pick_len(), s, ($urandom_range(0, 99) < 15), 4);
      end else if (r < 78) begin
        // Length out of range: zero, one past the bound, or anything above
        case ($urandom_range(0, 2))
          0:       len = 0;
          1:       len = LEN_BOUND + 1;
          default: len = $urandom_range(LEN_BOUND + 1, 65535);
        endcase
        send_header(16'(len));
      end else if (r < 86) begin
        // Wrong sync byte after a valid length
        do s = 8'($urandom); while (s == SYNC_A || s == SYNC_B);
        send_header(16'($urandom_range(1, 8)));
        send_item(1'b0, s);
      end else begin
        // Noise: stray bytes, an odd start byte, and tick runs near the limit
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 3))
            0:       send_ticks((cur_idle_limit > 12) ? $urandom_range(1, 4)
                                                      : $urandom_range(1, cur_idle_limit + 1));
            1:       send_item(1'b0, ($urandom_range(0, 7) == 0) ? START_BYTE : 8'($urandom));
            default: send_item(1'b0, 8'($urandom));
          endcase
        end
      end
    end
    burst_mode = 1'b0;
  endtask

  // Result side: random ready stretches and gaps, plus one long hold-off
  // while the sender keeps pushing so the output register fills and the
  // input stalls
  initial begin : result_sink
    int n;
    int k;
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        k = 0;
        while (k < SQUEEZE_CYCLES) begin
          @(posedge clk);
          k++;
        end
        squeeze_done = 1'b1;
      end else begin
        out_ready <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 20);
        k = 0;
        do begin
          @(posedge clk);
          k++;
        end while (k < n && !(squeeze_req && !squeeze_done));
        gap = idle_gap();
        if (gap > 0 && !(squeeze_req && !squeeze_done)) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    items_sent     = 0;
    burst_mode     = 1'b0;
    squeeze_req    = 1'b0;
    squeeze_done   = 1'b0;
    cur_idle_limit = IDLE_LIMIT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, register defaults
    send_header(16'h0000);                          // zero length
    send_header(16'hFFFF);                          // huge length, saturated report
    send_header(16'h0001);                          // bad sync byte
    send_item(1'b0, 8'h00);
    send_frame(TYPE_TEST, 1, SYNC_B, 1'b0, 0);      // good request with a reply
    send_frame(START_BYTE, 1, SYNC_A, 1'b1, 0);     // start byte as type, CRC spoiled
    send_item(1'b0, START_BYTE);                    // partial frame dropped by idling
    send_ticks(IDLE_LIMIT_RST);
    send_frame(TYPE_PLAIN, 1, SYNC_A, 1'b0, 0);     // fresh hunt finds this one
    drain();

    // Random part across register settings
    run_phase(PHASE_ITEMS);

    settle();
    write_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
    send_frame(TYPE_LOGIN, LEN_BOUND, SYNC_A, 1'b0, 0);  // longest legal body
    run_phase(PHASE_ITEMS);

    settle();
    write_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    squeeze_req = 1'b1;
    run_phase(PHASE_ITEMS);

    settle();
    write_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'h00);
    run_phase(PHASE_ITEMS);

    settle();
    write_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom_range(2, 12)));
    run_phase(PHASE_ITEMS);

    drain();
    if (mismatch_count == 0 && pending_frames == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
